@@ rtl/sifb_pkg.sv @@
// ----------------------------------------------------------------------------
// sifb_pkg: shared types and constants of the stuffed information frame builder
// Transfer payloads, configuration record, queue command word and register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sifb_pkg;

  // Configuration port geometry: seven 8-bit registers at word addresses.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CODE_W     = 8;

  // Default depth of the command queue between front and back.
  localparam int FIFO_DEPTH = 4;

  // Register reset values.
  localparam logic [CODE_W-1:0] RST_FLAG      = 8'd126;
  localparam logic [CODE_W-1:0] RST_ADDRESS   = 8'd3;
  localparam logic [CODE_W-1:0] RST_CTRL_ZERO = 8'd0;
  localparam logic [CODE_W-1:0] RST_CTRL_ONE  = 8'd64;
  localparam logic [CODE_W-1:0] RST_ESCAPE    = 8'd125;
  localparam logic [CODE_W-1:0] RST_FLAG_SUB  = 8'd94;
  localparam logic [CODE_W-1:0] RST_ESC_SUB   = 8'd93;

  typedef enum logic [2:0] {
    REG_FLAG      = 3'd0,
    REG_ADDRESS   = 3'd1,
    REG_CTRL_ZERO = 3'd2,
    REG_CTRL_ONE  = 3'd3,
    REG_ESCAPE    = 3'd4,
    REG_FLAG_SUB  = 3'd5,
    REG_ESC_SUB   = 3'd6
  } reg_idx_e;

  typedef enum logic {
    FUNC_PAYLOAD = 1'b0,
    FUNC_ACK     = 1'b1
  } func_e;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] payload_byte;
    logic              payload_last;
    logic              ack_is_reject;
    logic              ack_number;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_byte;
    logic              frame_end;
    logic              run_last;
    logic              is_ack_result;
    logic              ack_accepted;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] flag_code;
    logic [CODE_W-1:0] address_code;
    logic [CODE_W-1:0] control_seq_zero;
    logic [CODE_W-1:0] control_seq_one;
    logic [CODE_W-1:0] escape_code;
    logic [CODE_W-1:0] flag_substitute;
    logic [CODE_W-1:0] escape_substitute;
  } cfg_t;

  // One classified item as handed from the front to the back.
  typedef struct packed {
    logic              is_ack;
    logic              ack_accepted;
    logic              header;     // frame opens with this byte
    logic              last;       // frame closes with this byte
    logic [CODE_W-1:0] data;
    logic [CODE_W-1:0] ctrl;       // control byte latched at acceptance
    logic [CODE_W-1:0] check;      // running check including this byte
  } cmd_t;

endpackage

@@ rtl/sifb_regs.sv @@
// ----------------------------------------------------------------------------
// sifb_regs: configuration register file
// APB-style write and read access to the seven framing codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sifb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sifb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sifb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sifb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output sifb_pkg::cfg_t                     cfg_o
);
  import sifb_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  reg_idx_e          idx;
  logic [CODE_W-1:0] wr_code;
  logic [CODE_W-1:0] rd_code;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign idx     = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_code = pwdata[CODE_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FLAG:      cfg_d.flag_code         = wr_code;
        REG_ADDRESS:   cfg_d.address_code      = wr_code;
        REG_CTRL_ZERO: cfg_d.control_seq_zero  = wr_code;
        REG_CTRL_ONE:  cfg_d.control_seq_one   = wr_code;
        REG_ESCAPE:    cfg_d.escape_code       = wr_code;
        REG_FLAG_SUB:  cfg_d.flag_substitute   = wr_code;
        REG_ESC_SUB:   cfg_d.escape_substitute = wr_code;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FLAG:      rd_code = cfg_q.flag_code;
      REG_ADDRESS:   rd_code = cfg_q.address_code;
      REG_CTRL_ZERO: rd_code = cfg_q.control_seq_zero;
      REG_CTRL_ONE:  rd_code = cfg_q.control_seq_one;
      REG_ESCAPE:    rd_code = cfg_q.escape_code;
      REG_FLAG_SUB:  rd_code = cfg_q.flag_substitute;
      REG_ESC_SUB:   rd_code = cfg_q.escape_substitute;
      default:       rd_code = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, rd_code};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_code         <= RST_FLAG;
      cfg_q.address_code      <= RST_ADDRESS;
      cfg_q.control_seq_zero  <= RST_CTRL_ZERO;
      cfg_q.control_seq_one   <= RST_CTRL_ONE;
      cfg_q.escape_code       <= RST_ESCAPE;
      cfg_q.flag_substitute   <= RST_FLAG_SUB;
      cfg_q.escape_substitute <= RST_ESC_SUB;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/sifb_front.sv @@
// ----------------------------------------------------------------------------
// sifb_front: item intake and classification
// Keeps sequence bit, running check and frame state; builds queue commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sifb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sifb_pkg::in_item_t in_data_i,
  input  sifb_pkg::cfg_t     cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output sifb_pkg::cmd_t     cmd_o
);
  import sifb_pkg::*;

  logic              seq_q, seq_d;
  logic              in_frame_q, in_frame_d;
  logic [CODE_W-1:0] check_q, check_d;
  logic              accept;
  logic [CODE_W-1:0] new_check;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  // Restart the check on the first byte of a frame.
  assign new_check  = (in_frame_q ? check_q : '0) ^ in_data_i.payload_byte;

  always_comb begin
    seq_d      = seq_q;
    in_frame_d = in_frame_q;
    check_d    = check_q;

    cmd_o              = '0;
    cmd_o.data         = in_data_i.payload_byte;
    cmd_o.last         = in_data_i.payload_last;
    cmd_o.header       = !in_frame_q;
    cmd_o.ctrl         = seq_q ? cfg_i.control_seq_one : cfg_i.control_seq_zero;
    cmd_o.check        = new_check;

    if (func_e'(in_data_i.func) == FUNC_ACK) begin
      cmd_o.is_ack       = 1'b1;
      cmd_o.ack_accepted = in_data_i.ack_number != seq_q;
      if (accept) begin
        seq_d = seq_q ^ cmd_o.ack_accepted;
      end
    end else if (accept) begin
      if (in_data_i.payload_last) begin
        in_frame_d = 1'b0;
        check_d    = '0;
      end else begin
        in_frame_d = 1'b1;
        check_d    = new_check;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= 1'b0;
      in_frame_q <= 1'b0;
      check_q    <= '0;
    end else begin
      seq_q      <= seq_d;
      in_frame_q <= in_frame_d;
      check_q    <= check_d;
    end
  end

endmodule

@@ rtl/sifb_fifo.sv @@
// ----------------------------------------------------------------------------
// sifb_fifo: command queue
// Short first-in first-out store that decouples intake from byte emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sifb_fifo #(
  parameter int Depth = sifb_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sifb_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output sifb_pkg::cmd_t head_o,
  output logic           head_valid_o,
  output logic           full_o
);
  import sifb_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = count_q == FullCnt;
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/sifb_back.sv @@
// ----------------------------------------------------------------------------
// sifb_back: byte sequencer
// Walks header, stuffed payload, stuffed check, closing flag or ack result, one per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sifb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sifb_pkg::cfg_t      cfg_i,
  input  logic                head_valid_i,
  input  sifb_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sifb_pkg::out_item_t out_data_o
);
  import sifb_pkg::*;

  typedef enum logic [3:0] {
    PH_START,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_HCHK,
    PH_DATA,
    PH_DATA_SUB,
    PH_CHK,
    PH_CHK_SUB,
    PH_END,
    PH_ACK
  } phase_e;

  phase_e    phase_q, phase_d, cur;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  out_item_t res;
  logic      load_en, step, done, tail_data, tail_chk;
  logic      data_flag, data_esc, chk_flag, chk_esc;

  assign data_flag = cmd_i.data == cfg_i.flag_code;
  assign data_esc  = cmd_i.data == cfg_i.escape_code;
  assign chk_flag  = cmd_i.check == cfg_i.flag_code;
  assign chk_esc   = cmd_i.check == cfg_i.escape_code;

  assign load_en = !out_valid_q || !out_stall_i;
  assign step    = head_valid_i && load_en;

  always_comb begin
    phase_e nxt;
    cur       = phase_q;
    nxt       = PH_START;
    res       = '0;
    done      = 1'b0;
    tail_data = 1'b0;
    tail_chk  = 1'b0;

    if (phase_q == PH_START) begin
      cur = cmd_i.is_ack ? PH_ACK : (cmd_i.header ? PH_FLAG : PH_DATA);
    end

    case (cur)
      PH_FLAG: begin
        res.out_byte = cfg_i.flag_code;
        nxt          = PH_ADDR;
      end
      PH_ADDR: begin
        res.out_byte = cfg_i.address_code;
        nxt          = PH_CTRL;
      end
      PH_CTRL: begin
        res.out_byte = cmd_i.ctrl;
        nxt          = PH_HCHK;
      end
      PH_HCHK: begin
        res.out_byte = cfg_i.address_code ^ cmd_i.ctrl;
        nxt          = PH_DATA;
      end
      PH_DATA: begin
        if (data_flag || data_esc) begin
          res.out_byte = cfg_i.escape_code;
          nxt          = PH_DATA_SUB;
        end else begin
          res.out_byte = cmd_i.data;
          tail_data    = 1'b1;
        end
      end
      PH_DATA_SUB: begin
        // Flag test wins when flag and escape codes coincide.
        res.out_byte = data_flag ? cfg_i.flag_substitute : cfg_i.escape_substitute;
        tail_data    = 1'b1;
      end
      PH_CHK: begin
        if (chk_flag || chk_esc) begin
          res.out_byte = cfg_i.escape_code;
          nxt          = PH_CHK_SUB;
        end else begin
          res.out_byte = cmd_i.check;
          tail_chk     = 1'b1;
        end
      end
      PH_CHK_SUB: begin
        res.out_byte = chk_flag ? cfg_i.flag_substitute : cfg_i.escape_substitute;
        tail_chk     = 1'b1;
      end
      PH_END: begin
        res.out_byte  = cfg_i.flag_code;
        res.frame_end = 1'b1;
        done          = 1'b1;
      end
      PH_ACK: begin
        res.is_ack_result = 1'b1;
        res.ack_accepted  = cmd_i.ack_accepted;
        done              = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (tail_data) begin
      if (cmd_i.last) begin
        nxt = PH_CHK;
      end else begin
        done = 1'b1;
      end
    end
    if (tail_chk) begin
      nxt = PH_END;
    end
    if (done) begin
      nxt = PH_START;
    end
    res.run_last = done;

    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      phase_d     = nxt;
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (load_en) begin
      out_valid_d = 1'b0;
    end
  end

  assign pop_o       = step && done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // A command part way through its bytes stays at the queue head.
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_START |-> head_valid_i)
    else $error("sequencer mid-command without a queue head");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.run_last && !out_q.is_ack_result)
    else $error("closing flag not marked as final result");

  a_ack_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_ack_result |-> out_q.run_last && out_q.out_byte == '0)
    else $error("acknowledgement result malformed");

  a_pop_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_q.run_last)
    else $error("command retired without its final result");

endmodule

@@ rtl/stuffed_info_frame_builder.sv @@
// ----------------------------------------------------------------------------
// stuffed_info_frame_builder: byte-stuffed information frame transmitter
// Results: each accepted item gives 1 to 9 results, emitted one per cycle
//   by the byte sequencer unless the output stalls or the queue is empty;
//   a plain payload byte gives 1 or 2. The queue keeps taking new items
//   while the sequencer is still emitting an earlier one, until it is full.
// Reset: asynchronous, clears sequence bit, running check, frame state, queue
//   and output register; codes return to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stuffed_info_frame_builder #(
  parameter int FifoDepth = sifb_pkg::FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input item channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sifb_pkg::in_item_t              in_data_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sifb_pkg::out_item_t             out_data_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sifb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sifb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sifb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import sifb_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, pop, head_valid, full;

  // Framing codes; the user must write them only while no transfer is in flight; the block does not enforce it.
  sifb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front: take each transfer, advance frame state and the sequence bit,
  // and latch the control byte and running check into a command.
  sifb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Queue: hold commands while the back is busy stuffing a longer one.
  sifb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .pop_i        (pop),
    .head_o       (head_cmd),
    .head_valid_o (head_valid),
    .full_o       (full)
  );

  // Back: emit header, stuffed bytes, closing flag or ack result through the output
  // register, one result per cycle unless stalled, and retire the command on its last.
  sifb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
